// File: src/gregorian_solar_hijri_date_converter_defines.svh
// Assertion macros shared by the date converter RTL.
// Depends on nothing; included by the top level only.
`ifndef GREGORIAN_SOLAR_HIJRI_DATE_CONVERTER_DEFINES_SVH
`define GREGORIAN_SOLAR_HIJRI_DATE_CONVERTER_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define GSHDC_ASSERT_IMPLY(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Checks that a condition is followed by a delayed consequence.
`define GSHDC_ASSERT_DELAY2(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##2 (cons)) \
      else $error(msg);

`endif

// File: src/gshdc_pkg.sv
// Package for the date converter: transaction structs, direction codes
// and the month boundary and offset tables. Depends on nothing.
package gshdc_pkg;

   // Direction codes carried in the operation field.
   localparam logic OP_GREG_TO_HIJRI = 1'b0;
   localparam logic OP_HIJRI_TO_GREG = 1'b1;

   // Year offsets between the two calendars.
   localparam logic [11:0] YEAR_OFS_EARLY = 12'd621;
   localparam logic [11:0] YEAR_OFS_LATE  = 12'd622;
   localparam logic [11:0] YEAR_MAX       = 12'd4095;

   // Month numbers at which the target year changes, and the valid month range.
   localparam logic [3:0] GREG_NEW_YEAR_MONTH  = 4'd3;
   localparam logic [3:0] HIJRI_NEW_YEAR_MONTH = 4'd10;
   localparam logic [3:0] MONTH_FIRST          = 4'd1;
   localparam logic [3:0] MONTH_LAST           = 4'd12;

   // Input transaction.
   typedef struct packed {
      logic        operation;
      logic [11:0] date_year;
      logic [3:0]  date_month;
      logic [4:0]  date_day;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [11:0] result_year;
      logic [3:0]  result_month;
      logic [4:0]  result_day;
      logic        month_error;
   } rsp_type;

   // Gregorian source: boundary day and offset per row pair and month.
   // Row pair 0 serves year mod 4 = 0, pair 1 serves 1, pair 2 serves 2 and 3.
   localparam logic [4:0] GREG_BND [3][12] = '{
      '{5'd20, 5'd19, 5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20},
      '{5'd19, 5'd18, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21},
      '{5'd20, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21}
   };
   localparam logic [4:0] GREG_OFS [3][12] = '{
      '{5'd10, 5'd11, 5'd10, 5'd12, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd9, 5'd10, 5'd10},
      '{5'd11, 5'd12, 5'd10, 5'd11, 5'd10, 5'd10, 5'd9, 5'd9, 5'd9, 5'd8, 5'd9, 5'd9},
      '{5'd10, 5'd11, 5'd9, 5'd11, 5'd10, 5'd10, 5'd9, 5'd9, 5'd9, 5'd8, 5'd9, 5'd9}
   };

   // Solar Hijri source: pair 0 serves year mod 4 = 0 and 1, pair 1 serves 2,
   // pair 2 serves 3.
   localparam logic [4:0] HIJRI_BND [3][12] = '{
      '{5'd11, 5'd10, 5'd10, 5'd9, 5'd9, 5'd9, 5'd8, 5'd9, 5'd9, 5'd10, 5'd11, 5'd9},
      '{5'd11, 5'd10, 5'd10, 5'd9, 5'd9, 5'd9, 5'd8, 5'd9, 5'd9, 5'd10, 5'd11, 5'd10},
      '{5'd12, 5'd11, 5'd11, 5'd10, 5'd10, 5'd10, 5'd9, 5'd10, 5'd10, 5'd11, 5'd12, 5'd10}
   };
   localparam logic [4:0] HIJRI_OFS [3][12] = '{
      '{5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20, 5'd19},
      '{5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20, 5'd19},
      '{5'd19, 5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd21, 5'd21, 5'd20, 5'd20, 5'd19, 5'd18}
   };

endpackage

// File: src/gregorian_solar_hijri_date_converter.sv
// Top level of the Gregorian / solar Hijri date converter.
// Depends on gshdc_pkg, gshdc_convert and the assertion macro header.

// Converts one date per transaction between the Gregorian and solar Hijri
// calendars using a four-year table approximation. A transaction is taken at
// every clock edge where start is high; busy never rises, so one date may
// enter every cycle. Each result appears on rsp_data with rsp_valid high for
// exactly one cycle, after its transaction passes the input register and then
// the result register, with the table lookup and year arithmetic between
// them. The receiver cannot stall the block, so results must be captured
// when rsp_valid is high.
`include "gregorian_solar_hijri_date_converter_defines.svh"

module gregorian_solar_hijri_date_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gshdc_pkg::req_type req_data,
   output logic               rsp_valid,
   output gshdc_pkg::rsp_type rsp_data
);

   logic               req_valid_ff;
   logic               req_valid_in;
   gshdc_pkg::req_type req_data_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   gshdc_pkg::rsp_type rsp_data_ff;
   gshdc_pkg::rsp_type rsp_data_in;

   // The pipeline never holds off a new transaction.
   assign busy = 1'b0;

   assign req_valid_in = start && !busy;
   assign rsp_valid_in = req_valid_ff;

   // Valid bit control for the input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_data_ff <= req_data;
      end
      if (rsp_valid_in) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Conversion logic between the two registers.
   gshdc_convert u_convert (
      .req (req_data_ff),
      .rsp (rsp_data_in)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Every accepted transaction yields a result strobe.
   `GSHDC_ASSERT_DELAY2(a_accept_to_result, clock, reset, start && !busy, rsp_valid, "result strobe missing after an accepted transaction")

   // A month error carries an all-zero date.
   `GSHDC_ASSERT_IMPLY(a_error_zeroes, clock, reset, rsp_valid && rsp_data.month_error, (rsp_data.result_year == 12'd0) && (rsp_data.result_month == 4'd0) && (rsp_data.result_day == 5'd0), "month error result has a nonzero date")

   // A valid conversion lands on a real month.
   `GSHDC_ASSERT_IMPLY(a_month_range, clock, reset, rsp_valid && !rsp_data.month_error, (rsp_data.result_month >= 4'd1) && (rsp_data.result_month <= 4'd12), "converted month outside one to twelve")

endmodule

// File: src/gshdc_convert.sv
// Combinational date conversion between the input and result registers.
// Depends on gshdc_pkg for the transaction structs and the month tables.
module gshdc_convert (
   input  gshdc_pkg::req_type req,
   output gshdc_pkg::rsp_type rsp
);

   logic        month_ok;
   logic [3:0]  col;
   logic [1:0]  greg_row;
   logic [1:0]  hijri_row;
   logic [4:0]  bnd;
   logic [4:0]  ofs;
   logic        before_bnd;
   logic        greg_early;
   logic [11:0] greg_sub;
   logic        hijri_early;
   logic [12:0] hijri_sum;
   logic [5:0]  day_sum;
   logic [11:0] year_val;
   logic [3:0]  month_val;
   logic [4:0]  day_val;

   // Month range check and table column.
   assign month_ok = (req.date_month >= gshdc_pkg::MONTH_FIRST) &&
                     (req.date_month <= gshdc_pkg::MONTH_LAST);
   assign col = month_ok ? (req.date_month - 4'd1) : 4'd0;

   // Row pair selection from the low two bits of the year.
   always_comb begin
      case (req.date_year[1:0])
         2'd0:    greg_row = 2'd0;
         2'd1:    greg_row = 2'd1;
         default: greg_row = 2'd2;
      endcase
      case (req.date_year[1:0])
         2'd2:    hijri_row = 2'd1;
         2'd3:    hijri_row = 2'd2;
         default: hijri_row = 2'd0;
      endcase
   end

   // Boundary and offset lookup for the chosen direction.
   always_comb begin
      if (req.operation == gshdc_pkg::OP_GREG_TO_HIJRI) begin
         bnd = gshdc_pkg::GREG_BND[greg_row][col];
         ofs = gshdc_pkg::GREG_OFS[greg_row][col];
      end else begin
         bnd = gshdc_pkg::HIJRI_BND[hijri_row][col];
         ofs = gshdc_pkg::HIJRI_OFS[hijri_row][col];
      end
   end

   assign before_bnd = (req.date_day <= bnd);

   // Year arithmetic. The Gregorian side saturates at zero, the Hijri side at
   // the top of the field.
   assign greg_early = (req.date_month < gshdc_pkg::GREG_NEW_YEAR_MONTH) ||
                       ((req.date_month == gshdc_pkg::GREG_NEW_YEAR_MONTH) && before_bnd);
   assign greg_sub   = greg_early ? gshdc_pkg::YEAR_OFS_LATE : gshdc_pkg::YEAR_OFS_EARLY;

   assign hijri_early = (req.date_month < gshdc_pkg::HIJRI_NEW_YEAR_MONTH) ||
                        ((req.date_month == gshdc_pkg::HIJRI_NEW_YEAR_MONTH) && before_bnd);
   assign hijri_sum   = {1'b0, req.date_year} +
                        {1'b0, (hijri_early ? gshdc_pkg::YEAR_OFS_EARLY
                                            : gshdc_pkg::YEAR_OFS_LATE)};

   // Day of the target month, kept to the field width.
   assign day_sum = before_bnd ? ({1'b0, req.date_day} + {1'b0, ofs})
                               : ({1'b0, req.date_day} - {1'b0, bnd});

   // Target year, month and day.
   always_comb begin
      if (req.operation == gshdc_pkg::OP_GREG_TO_HIJRI) begin
         year_val = (req.date_year >= greg_sub) ? (req.date_year - greg_sub) : 12'd0;
         if (before_bnd) begin
            month_val = (req.date_month <= 4'd3) ? (req.date_month + 4'd9)
                                                 : (req.date_month - 4'd3);
         end else begin
            month_val = (req.date_month <= 4'd2) ? (req.date_month + 4'd10)
                                                 : (req.date_month - 4'd2);
         end
      end else begin
         year_val = hijri_sum[12] ? gshdc_pkg::YEAR_MAX : hijri_sum[11:0];
         if (before_bnd) begin
            month_val = (req.date_month <= 4'd10) ? (req.date_month + 4'd2)
                                                  : (req.date_month - 4'd10);
         end else begin
            month_val = (req.date_month <= 4'd9) ? (req.date_month + 4'd3)
                                                 : (req.date_month - 4'd9);
         end
      end
      day_val = day_sum[4:0];
   end

   // An invalid month zeroes the date and raises the error flag.
   always_comb begin
      if (month_ok) begin
         rsp.result_year  = year_val;
         rsp.result_month = month_val;
         rsp.result_day   = day_val;
         rsp.month_error  = 1'b0;
      end else begin
         rsp.result_year  = 12'd0;
         rsp.result_month = 4'd0;
         rsp.result_day   = 5'd0;
         rsp.month_error  = 1'b1;
      end
   end

endmodule

// File: sim/gregorian_solar_hijri_date_converter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Gregorian / solar Hijri date converter.
// Depends on gshdc_pkg and the gregorian_solar_hijri_date_converter RTL.
module gregorian_solar_hijri_date_converter_tb;

   localparam int IDLE_LIMIT  = 2000;
   localparam int MAX_REPORTS = 40;
   localparam int PHASE_ITEMS = 332;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   gshdc_pkg::req_type req_data  = '0;
   logic               busy;
   logic               rsp_valid;
   gshdc_pkg::rsp_type rsp_data;

   gshdc_pkg::req_type pending_dates[$];
   gshdc_pkg::rsp_type expected_dates[$];
   int                 sender_idle_pct = 0;
   int                 fail_count      = 0;
   int                 idle_cycles     = 0;

   gregorian_solar_hijri_date_converter DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // Free-running clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Gregorian source rows, month 1 leftmost: even rows hold the boundary
   // day, odd rows the day offset. Pairs serve year mod 4 = 0, 1, and 2 or 3.
   function automatic logic [59:0] greg_row(int sel);
      case (sel)
         0: return {5'd20,5'd19,5'd19,5'd19,5'd20,5'd20,5'd21,5'd21,5'd21,5'd21,5'd20,5'd20};
         1: return {5'd10,5'd11,5'd10,5'd12,5'd11,5'd11,5'd10,5'd10,5'd10,5'd9,5'd10,5'd10};
         2: return {5'd19,5'd18,5'd20,5'd20,5'd21,5'd21,5'd22,5'd22,5'd22,5'd22,5'd21,5'd21};
         3: return {5'd11,5'd12,5'd10,5'd11,5'd10,5'd10,5'd9,5'd9,5'd9,5'd8,5'd9,5'd9};
         4: return {5'd20,5'd19,5'd20,5'd20,5'd21,5'd21,5'd22,5'd22,5'd22,5'd22,5'd21,5'd21};
         5: return {5'd10,5'd11,5'd9,5'd11,5'd10,5'd10,5'd9,5'd9,5'd9,5'd8,5'd9,5'd9};
         default: return '0;
      endcase
   endfunction

   // Solar Hijri source rows in the same layout. Pairs serve year mod 4 of
   // 0 or 1, then 2, then 3.
   function automatic logic [59:0] hijri_row(int sel);
      case (sel)
         0: return {5'd11,5'd10,5'd10,5'd9,5'd9,5'd9,5'd8,5'd9,5'd9,5'd10,5'd11,5'd9};
         1: return {5'd20,5'd20,5'd21,5'd21,5'd22,5'd22,5'd22,5'd22,5'd21,5'd21,5'd20,5'd19};
         2: return {5'd11,5'd10,5'd10,5'd9,5'd9,5'd9,5'd8,5'd9,5'd9,5'd10,5'd11,5'd10};
         3: return {5'd20,5'd20,5'd21,5'd21,5'd22,5'd22,5'd22,5'd22,5'd21,5'd21,5'd20,5'd19};
         4: return {5'd12,5'd11,5'd11,5'd10,5'd10,5'd10,5'd9,5'd10,5'd10,5'd11,5'd12,5'd10};
         5: return {5'd19,5'd19,5'd20,5'd20,5'd21,5'd21,5'd21,5'd21,5'd20,5'd20,5'd19,5'd18};
         default: return '0;
      endcase
   endfunction

   // Predicts the converted date for one input transaction.
   function automatic gshdc_pkg::rsp_type convert_date(gshdc_pkg::req_type d);
      gshdc_pkg::rsp_type r;
      int                 year;
      int                 month;
      int                 day;
      int                 pair;
      int                 bnd;
      int                 ofs;
      logic [59:0]        brow;
      logic [59:0]        orow;
      r     = '0;
      year  = int'(d.date_year);
      month = int'(d.date_month);
      day   = int'(d.date_day);
      if (month < int'(gshdc_pkg::MONTH_FIRST) || month > int'(gshdc_pkg::MONTH_LAST)) begin
         r.month_error = 1'b1;
         return r;
      end
      if (d.operation == gshdc_pkg::OP_GREG_TO_HIJRI) begin
         pair = (year % 4 == 3) ? 2 : year % 4;
         brow = greg_row(2 * pair);
         orow = greg_row(2 * pair + 1);
      end else begin
         pair = (year % 4 <= 1) ? 0 : year % 4 - 1;
         brow = hijri_row(2 * pair);
         orow = hijri_row(2 * pair + 1);
      end
      bnd = int'(brow[(12 - month) * 5 +: 5]);
      ofs = int'(orow[(12 - month) * 5 +: 5]);

      // The year changes at the new-year boundary; clamp at both ends.
      if (d.operation == gshdc_pkg::OP_GREG_TO_HIJRI) begin
         if (month < int'(gshdc_pkg::GREG_NEW_YEAR_MONTH) ||
             (month == int'(gshdc_pkg::GREG_NEW_YEAR_MONTH) && day <= bnd))
            year = year - 622;
         else
            year = year - 621;
         if (year < 0)
            year = 0;
      end else begin
         if (month < int'(gshdc_pkg::HIJRI_NEW_YEAR_MONTH) ||
             (month == int'(gshdc_pkg::HIJRI_NEW_YEAR_MONTH) && day <= bnd))
            year = year + 621;
         else
            year = year + 622;
         if (year > 4095)
            year = 4095;
      end

      // Before the boundary the offset is added; after it the boundary is removed.
      if (day <= bnd) begin
         day   = day + ofs;
         month = (d.operation == gshdc_pkg::OP_GREG_TO_HIJRI) ? (month + 8) % 12 + 1
                                                              : (month + 1) % 12 + 1;
      end else begin
         day   = day - bnd;
         month = (d.operation == gshdc_pkg::OP_GREG_TO_HIJRI) ? (month + 9) % 12 + 1
                                                              : (month + 2) % 12 + 1;
      end
      r.result_year  = 12'(year);
      r.result_month = 4'(month);
      r.result_day   = 5'(day);
      return r;
   endfunction

   task automatic queue_date(logic op, int year, int month, int day);
      gshdc_pkg::req_type d;
      d.operation  = op;
      d.date_year  = 12'(year);
      d.date_month = 4'(month);
      d.date_day   = 5'(day);
      pending_dates.push_back(d);
   endtask

   task automatic report_field(string name, int want, int got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
   endtask

   // Driver: records accepted transactions and presents the next pending date.
   always @(posedge clock) begin : driver
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_dates.push_back(convert_date(req_data));
            pending_dates.delete(0);
         end
         if (pending_dates.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            start    <= 1'b1;
            req_data <= pending_dates[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compares every result strobe with the oldest prediction.
   always @(posedge clock) begin : monitor
      gshdc_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_dates.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
         end else begin
            want = expected_dates.pop_front();
            if (rsp_data.result_year != want.result_year)
               report_field("result_year", int'(want.result_year),
                            int'(rsp_data.result_year));
            if (rsp_data.result_month != want.result_month)
               report_field("result_month", int'(want.result_month),
                            int'(rsp_data.result_month));
            if (rsp_data.result_day != want.result_day)
               report_field("result_day", int'(want.result_day),
                            int'(rsp_data.result_day));
            if (rsp_data.month_error != want.month_error)
               report_field("month_error", int'(want.month_error),
                            int'(rsp_data.month_error));
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("** gregorian_solar_hijri_date_converter: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus: directed dates, then random phases with different sender idling.
   initial begin : stimulus
      int idle_plan[4];
      idle_plan = '{0, 75, 0, 33};

      // Year boundaries, clamping, bad months, day zero and days past month end.
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 2024, 3, 19);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 2024, 3, 20);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 2025, 1, 31);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 2026, 12, 0);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 2027, 2, 31);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 2024, 4, 5);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 2025, 4, 25);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 0, 1, 1);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 621, 5, 30);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 622, 2, 10);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 4095, 6, 31);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 700, 0, 5);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 3000, 13, 20);
      queue_date(gshdc_pkg::OP_GREG_TO_HIJRI, 1999, 15, 31);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 1403, 10, 11);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 1403, 10, 12);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 1400, 1, 1);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 1401, 12, 31);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 1402, 9, 30);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 3473, 11, 5);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 3474, 12, 20);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 4095, 7, 0);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 0, 4, 15);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 700, 0, 0);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 4095, 15, 31);
      queue_date(gshdc_pkg::OP_HIJRI_TO_GREG, 3000, 14, 1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // The receiver cannot stall, so each phase only sets the sender's idling.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = idle_plan[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_date(1'($urandom_range(1)),
                       ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(3000, 700),
                       ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 1),
                       ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(31, 1));
         end
         while (pending_dates.size() != 0)
            @(posedge clock);
      end

      // Drain the pipeline and give stray results a chance to show up.
      while (expected_dates.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("** gregorian_solar_hijri_date_converter: PASSED **");
      else
         $display("** gregorian_solar_hijri_date_converter: FAILED **");
      $finish;
   end

endmodule

// File: gregorian_solar_hijri_date_converter.f
+incdir+src
src/gshdc_pkg.sv
src/gshdc_convert.sv
src/gregorian_solar_hijri_date_converter.sv
sim/gregorian_solar_hijri_date_converter_tb.sv
